[sv/cbf_pkg.sv]
package cbf_pkg;

    localparam int STEPS_W  = 7;
    localparam int COORD_W  = 32;
    localparam int WEIGHT_W = 19;
    localparam int SQ3_W    = 14;
    localparam int SUM_W    = 52;
    localparam int ITER_W   = 5;
    localparam int TBL_LAST = 64;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd30;
    localparam logic [ITER_W-1:0]  ITER_LAST   = 5'd31;

    // path command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LINE  = 2'd1,
        CMD_CUBIC = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]                cmd;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [COORD_W-1:0]        path_length;
        logic                      last;
    } t_out_word;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_ACCEPT,
        OP_MUL_W1,
        OP_MUL_W2,
        OP_STORE_W2,
        OP_MUL_T0,
        OP_MUL_T1,
        OP_MUL_T2,
        OP_MUL_T3,
        OP_SUM_ADD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_MUL_DX,
        OP_MUL_DY,
        OP_SQ_ADD,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_LEN_ADD,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic more_points;
    } t_dp_status;

    typedef enum logic [4:0] {
        S_IDLE, S_W1, S_W2, S_WS,
        S_T0, S_T1, S_T2, S_T3, S_TA,
        S_DI, S_DV, S_DF,
        S_DX, S_DY, S_SA, S_RI, S_RS, S_RF,
        S_EM
    } t_state;

    typedef logic [TBL_LAST:0][WEIGHT_W-1:0] t_cube_tbl;
    typedef logic [TBL_LAST:0][SQ3_W-1:0]    t_sq3_tbl;

    function automatic t_cube_tbl f_cube_tbl();
        t_cube_tbl tbl;
        for (int k = 0; k <= TBL_LAST; k++) begin
            tbl[k] = WEIGHT_W'(k * k * k);
        end
        return tbl;
    endfunction

    function automatic t_sq3_tbl f_sq3_tbl();
        t_sq3_tbl tbl;
        for (int k = 0; k <= TBL_LAST; k++) begin
            tbl[k] = SQ3_W'(3 * k * k);
        end
        return tbl;
    endfunction

    // k cubed and three times k squared
    localparam t_cube_tbl CUBE_TBL = f_cube_tbl();
    localparam t_sq3_tbl  SQ3_TBL  = f_sq3_tbl();

endpackage

[sv/cbf_ctrl.sv]
module cbf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_cmd_code,
    input  cbf_pkg::t_dp_status  i_status,
    output logic                 o_in_ready,
    output cbf_pkg::t_dp_cmd     o_cmd
);

    cbf_pkg::t_state                 r_state, n_state;
    logic                            r_axis, n_axis;
    logic [cbf_pkg::ITER_W-1:0]      r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbf_pkg::S_IDLE;
            r_axis  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_cnt   <= n_cnt;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd.op   = cbf_pkg::OP_IDLE;
        o_cmd.axis = r_axis;
        case (r_state)
            cbf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_axis     = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = cbf_pkg::OP_ACCEPT;
                    case (i_cmd_code)
                        cbf_pkg::CMD_START: n_state = cbf_pkg::S_EM;
                        cbf_pkg::CMD_LINE:  n_state = cbf_pkg::S_DX;
                        cbf_pkg::CMD_CUBIC: n_state = cbf_pkg::S_W1;
                        default:            n_state = cbf_pkg::S_IDLE;
                    endcase
                end
            end
            cbf_pkg::S_W1: begin
                o_cmd.op = cbf_pkg::OP_MUL_W1;
                n_state  = cbf_pkg::S_W2;
            end
            cbf_pkg::S_W2: begin
                o_cmd.op = cbf_pkg::OP_MUL_W2;
                n_state  = cbf_pkg::S_WS;
            end
            cbf_pkg::S_WS: begin
                o_cmd.op = cbf_pkg::OP_STORE_W2;
                n_axis   = 1'b0;
                n_state  = cbf_pkg::S_T0;
            end
            cbf_pkg::S_T0: begin
                o_cmd.op = cbf_pkg::OP_MUL_T0;
                n_state  = cbf_pkg::S_T1;
            end
            cbf_pkg::S_T1: begin
                o_cmd.op = cbf_pkg::OP_MUL_T1;
                n_state  = cbf_pkg::S_T2;
            end
            cbf_pkg::S_T2: begin
                o_cmd.op = cbf_pkg::OP_MUL_T2;
                n_state  = cbf_pkg::S_T3;
            end
            cbf_pkg::S_T3: begin
                o_cmd.op = cbf_pkg::OP_MUL_T3;
                n_state  = cbf_pkg::S_TA;
            end
            cbf_pkg::S_TA: begin
                o_cmd.op = cbf_pkg::OP_SUM_ADD;
                n_state  = cbf_pkg::S_DI;
            end
            cbf_pkg::S_DI: begin
                o_cmd.op = cbf_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = cbf_pkg::S_DV;
            end
            cbf_pkg::S_DV: begin
                o_cmd.op = cbf_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == cbf_pkg::ITER_LAST) begin
                    n_state = cbf_pkg::S_DF;
                end
            end
            cbf_pkg::S_DF: begin
                o_cmd.op = cbf_pkg::OP_DIV_FIN;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = cbf_pkg::S_T0;
                end else begin
                    n_state = cbf_pkg::S_DX;
                end
            end
            cbf_pkg::S_DX: begin
                o_cmd.op = cbf_pkg::OP_MUL_DX;
                n_state  = cbf_pkg::S_DY;
            end
            cbf_pkg::S_DY: begin
                o_cmd.op = cbf_pkg::OP_MUL_DY;
                n_state  = cbf_pkg::S_SA;
            end
            cbf_pkg::S_SA: begin
                o_cmd.op = cbf_pkg::OP_SQ_ADD;
                n_state  = cbf_pkg::S_RI;
            end
            cbf_pkg::S_RI: begin
                o_cmd.op = cbf_pkg::OP_ROOT_INIT;
                n_cnt    = '0;
                n_state  = cbf_pkg::S_RS;
            end
            cbf_pkg::S_RS: begin
                o_cmd.op = cbf_pkg::OP_ROOT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == cbf_pkg::ITER_LAST) begin
                    n_state = cbf_pkg::S_RF;
                end
            end
            cbf_pkg::S_RF: begin
                o_cmd.op = cbf_pkg::OP_LEN_ADD;
                n_state  = cbf_pkg::S_EM;
            end
            cbf_pkg::S_EM: begin
                if (i_status.out_free) begin
                    o_cmd.op = cbf_pkg::OP_EMIT;
                    n_state  = i_status.more_points ? cbf_pkg::S_W1 : cbf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbf_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[sv/cbf_dp.sv]
module cbf_dp #(
    parameter int MAX_STEPS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cbf_pkg::t_dp_cmd                   i_cmd,
    output cbf_pkg::t_dp_status                o_status,
    input  cbf_pkg::t_in_word                  i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [cbf_pkg::STEPS_W-1:0]        i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output cbf_pkg::t_out_word                 o_out_data
);

    localparam int CW = cbf_pkg::COORD_W;
    localparam int WW = cbf_pkg::WEIGHT_W;
    localparam int NW = cbf_pkg::STEPS_W;
    localparam int SW = cbf_pkg::SUM_W;

    // control state
    logic [NW-1:0]          r_steps;
    logic [CW-1:0]          r_acc;
    logic signed [CW-1:0]   r_cur_x, r_cur_y;
    logic                   r_out_valid;

    // payload
    cbf_pkg::t_in_word      r_in;
    cbf_pkg::t_out_word     r_out;
    logic [NW-1:0]          r_n, r_j;
    logic [WW-1:0]          r_den, r_w1, r_w2;
    logic signed [CW-1:0]   r_p0_x, r_p0_y, r_tx, r_ty;
    logic signed [65:0]     r_prod;
    logic [SW-1:0]          r_sum;
    logic                   r_neg;
    logic [WW-1:0]          r_rem;
    logic [CW-1:0]          r_dq;
    logic [64:0]            r_sq;
    logic                   r_ovf;
    logic [63:0]            r_rv;
    logic [CW-1:0]          r_root;
    logic [33:0]            r_srem;

    logic [NW-1:0]          n_clamp, a_idx;
    logic [WW-1:0]          w0, w3;
    logic [cbf_pkg::SQ3_W-1:0] sq3_a, sq3_b;
    logic signed [CW-1:0]   p0_c, c1_c, c2_c, e_c;
    logic signed [CW:0]     dx, dy, mul_a, mul_b;
    logic [WW-1:0]          half;
    logic [SW-1:0]          dvd;
    logic [WW:0]            div_t, div_d;
    logic                   div_ge;
    logic [CW-1:0]          qv;
    logic [35:0]            sq_t, sq_trial, sq_d;
    logic                   sq_ge, inc;
    logic [33:0]            tot;
    logic                   more;

    // step count clamp
    always_comb begin
        if (r_steps == '0) begin
            n_clamp = NW'(1);
        end else if (r_steps > NW'(MAX_STEPS)) begin
            n_clamp = NW'(MAX_STEPS);
        end else begin
            n_clamp = r_steps;
        end
    end

    // blend weights for the current point index
    assign a_idx = r_n - r_j;
    assign w0    = cbf_pkg::CUBE_TBL[a_idx];
    assign w3    = cbf_pkg::CUBE_TBL[r_j];
    assign sq3_a = cbf_pkg::SQ3_TBL[a_idx];
    assign sq3_b = cbf_pkg::SQ3_TBL[r_j];

    // coordinate of the axis being worked on
    assign p0_c = i_cmd.axis ? r_p0_y       : r_p0_x;
    assign c1_c = i_cmd.axis ? r_in.ctrl1_y : r_in.ctrl1_x;
    assign c2_c = i_cmd.axis ? r_in.ctrl2_y : r_in.ctrl2_x;
    assign e_c  = i_cmd.axis ? r_in.end_y   : r_in.end_x;

    assign dx = {r_tx[CW-1], r_tx} - {r_cur_x[CW-1], r_cur_x};
    assign dy = {r_ty[CW-1], r_ty} - {r_cur_y[CW-1], r_cur_y};

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            cbf_pkg::OP_MUL_W1: begin
                mul_a = $signed({{(CW+1-cbf_pkg::SQ3_W){1'b0}}, sq3_a});
                mul_b = $signed({{(CW+1-NW){1'b0}}, r_j});
            end
            cbf_pkg::OP_MUL_W2: begin
                mul_a = $signed({{(CW+1-cbf_pkg::SQ3_W){1'b0}}, sq3_b});
                mul_b = $signed({{(CW+1-NW){1'b0}}, a_idx});
            end
            cbf_pkg::OP_MUL_T0: begin
                mul_a = $signed({{(CW+1-WW){1'b0}}, w0});
                mul_b = {p0_c[CW-1], p0_c};
            end
            cbf_pkg::OP_MUL_T1: begin
                mul_a = $signed({{(CW+1-WW){1'b0}}, r_w1});
                mul_b = {c1_c[CW-1], c1_c};
            end
            cbf_pkg::OP_MUL_T2: begin
                mul_a = $signed({{(CW+1-WW){1'b0}}, r_w2});
                mul_b = {c2_c[CW-1], c2_c};
            end
            cbf_pkg::OP_MUL_T3: begin
                mul_a = $signed({{(CW+1-WW){1'b0}}, w3});
                mul_b = {e_c[CW-1], e_c};
            end
            cbf_pkg::OP_MUL_DX: begin
                mul_a = dx;
                mul_b = dx;
            end
            cbf_pkg::OP_MUL_DY: begin
                mul_a = dy;
                mul_b = dy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // rounded division: magnitude plus half divisor, restoring steps
    assign half   = {1'b0, r_den[WW-1:1]};
    assign dvd    = r_sum[SW-1] ? ({{(SW-WW){1'b0}}, half} - r_sum)
                                : (r_sum + {{(SW-WW){1'b0}}, half});
    assign div_t  = {r_rem, r_dq[CW-1]};
    assign div_ge = div_t >= {1'b0, r_den};
    assign div_d  = div_ge ? (div_t - {1'b0, r_den}) : div_t;
    assign qv     = r_neg ? (CW'(0) - r_dq) : r_dq;

    // square root, two radicand bits per step
    assign sq_t     = {r_srem, r_rv[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign sq_d     = sq_ge ? (sq_t - sq_trial) : sq_t;
    assign inc      = r_srem > {2'b00, r_root};
    assign tot      = {2'b00, r_acc} + {2'b00, r_root} + {33'd0, inc};

    assign more = (r_in.cmd == cbf_pkg::CMD_CUBIC) && (r_j != r_n);

    assign o_status.out_free    = !r_out_valid || i_out_ready;
    assign o_status.more_points = more;
    assign o_out_valid          = r_out_valid;
    assign o_out_data           = r_out;

    // configuration, path state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= cbf_pkg::STEPS_RESET;
            r_acc       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_steps <= i_cfg_data;
            end
            if (i_cmd.op == cbf_pkg::OP_ACCEPT && i_in_data.cmd == cbf_pkg::CMD_START) begin
                r_acc <= '0;
            end
            if (i_cmd.op == cbf_pkg::OP_LEN_ADD) begin
                if (r_ovf || tot[33:32] != 2'b00) begin
                    r_acc <= '1;
                end else begin
                    r_acc <= tot[CW-1:0];
                end
            end
            if (i_cmd.op == cbf_pkg::OP_EMIT) begin
                r_cur_x     <= r_tx;
                r_cur_y     <= r_ty;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (i_cmd.op)
            cbf_pkg::OP_ACCEPT: begin
                r_in   <= i_in_data;
                r_tx   <= i_in_data.end_x;
                r_ty   <= i_in_data.end_y;
                r_p0_x <= r_cur_x;
                r_p0_y <= r_cur_y;
                r_j    <= NW'(1);
                r_n    <= n_clamp;
                r_den  <= cbf_pkg::CUBE_TBL[n_clamp];
            end
            cbf_pkg::OP_MUL_W2:   r_w1  <= r_prod[WW-1:0];
            cbf_pkg::OP_STORE_W2: r_w2  <= r_prod[WW-1:0];
            cbf_pkg::OP_MUL_T1:   r_sum <= r_prod[SW-1:0];
            cbf_pkg::OP_MUL_T2,
            cbf_pkg::OP_MUL_T3,
            cbf_pkg::OP_SUM_ADD:  r_sum <= r_sum + r_prod[SW-1:0];
            cbf_pkg::OP_DIV_INIT: begin
                r_neg <= r_sum[SW-1];
                r_rem <= {1'b0, dvd[49:32]};
                r_dq  <= dvd[CW-1:0];
            end
            cbf_pkg::OP_DIV_STEP: begin
                r_rem <= div_d[WW-1:0];
                r_dq  <= {r_dq[CW-2:0], div_ge};
            end
            cbf_pkg::OP_DIV_FIN: begin
                if (i_cmd.axis) begin
                    r_ty <= qv;
                end else begin
                    r_tx <= qv;
                end
            end
            cbf_pkg::OP_MUL_DY:   r_sq <= {1'b0, r_prod[63:0]};
            cbf_pkg::OP_SQ_ADD:   r_sq <= r_sq + {1'b0, r_prod[63:0]};
            cbf_pkg::OP_ROOT_INIT: begin
                r_ovf  <= r_sq[64];
                r_rv   <= r_sq[63:0];
                r_root <= '0;
                r_srem <= '0;
            end
            cbf_pkg::OP_ROOT_STEP: begin
                r_srem <= sq_d[33:0];
                r_root <= {r_root[CW-2:0], sq_ge};
                r_rv   <= {r_rv[61:0], 2'b00};
            end
            cbf_pkg::OP_EMIT: begin
                r_out.vertex_x    <= r_tx;
                r_out.vertex_y    <= r_ty;
                r_out.path_length <= r_acc;
                r_out.last        <= !more;
                if (more) begin
                    r_j <= r_j + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/cubic_bezier_flattener_arclen.sv]
// start command: after the command word is accepted, the emit state registers the vertex word once the output is free
// line command: two squares, 32-step square root, length add
// cubic: per vertex weights, 2 x 32-step division, root; n vertices
// one command at a time; the shared multiplier and the bit-serial divider and root set the rate
// synchronous active-low reset: steps 30, current point and length zero, output empty
module cubic_bezier_flattener_arclen #(
    parameter int MAX_STEPS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cbf_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cbf_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbf_pkg::STEPS_W-1:0]   i_cfg_data
);

    cbf_pkg::t_dp_cmd    dp_cmd;
    cbf_pkg::t_dp_status dp_status;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    cbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd_code (i_in_data.cmd),
        .i_status   (dp_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    cbf_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[sv/cbf_checker.sv]
module cbf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input cbf_pkg::t_in_word             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input cbf_pkg::t_out_word            o_out_data
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    // a real command keeps the input closed in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.cmd != cbf_pkg::CMD_NONE |=> !o_in_ready)
        else $error("input reopened during a command");

    // a new output word only comes while a command is in progress
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("output word appeared while idle");

endmodule

bind cubic_bezier_flattener_arclen cbf_checker u_chk (.*);

[verif/tb_cubic_bezier_flattener_arclen.sv]
module tb_cubic_bezier_flattener_arclen;

    localparam int  CYCLE_LIMIT = 20000000;
    localparam int  DRAIN_WAIT  = 400;
    localparam int  N_DIR       = 16;
    localparam logic [31:0] LEN_SAT = 32'hFFFF_FFFF;
    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    typedef struct {
        cbf_pkg::t_in_word  w;
        bit                 chk;
        cbf_pkg::t_out_word e;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    cbf_pkg::t_in_word   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    cbf_pkg::t_out_word  o_out_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [cbf_pkg::STEPS_W-1:0] i_cfg_data = '0;

    // predictor state
    logic [6:0]         pr_steps;
    logic signed [31:0] pr_cur_x, pr_cur_y;
    logic [31:0]        pr_len;

    cbf_pkg::t_out_word vertex_q[$];
    t_dir_row  dir_tbl[N_DIR];
    int        fails = 0;
    int        cyc = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    bit        hold_req = 0;

    cubic_bezier_flattener_arclen DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter and run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // append one expected vertex word
    task automatic queue_vertex(cbf_pkg::t_out_word v);
        vertex_q.insert(vertex_q.size(), v);
    endtask

    // rounded square root, bit by bit on the root
    function automatic logic [32:0] round_root(logic [63:0] v);
        logic [63:0] r, t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        if (v - r * r > r) r = r + 1;
        return r[32:0];
    endfunction

    // add one segment to the running length, saturating
    task automatic add_segment(longint x0, longint y0, longint x1, longint y1);
        longint      dx, dy;
        logic [63:0] mx, my;
        logic [64:0] sq;
        logic [33:0] tot;
        dx = x1 - x0;
        dy = y1 - y0;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        sq = {1'b0, mx * mx} + {1'b0, my * my};
        if (sq[64]) begin
            pr_len = LEN_SAT;
        end else begin
            tot = {1'b0, pr_len} + {1'b0, round_root(sq[63:0])};
            pr_len = tot[33:32] != 0 ? LEN_SAT : tot[31:0];
        end
    endtask

    function automatic longint curve_coord(longint p0, longint p1, longint p2, longint p3,
                                           longint n, longint j);
        longint a, num, den, q, mag;
        a = n - j;
        num = a*a*a*p0 + 3*a*a*j*p1 + 3*a*j*j*p2 + j*j*j*p3;
        den = n * n * n;
        mag = num < 0 ? -num : num;
        q = (mag + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic cbf_pkg::t_out_word mk_vertex(longint x, longint y, logic [31:0] l,
                                                     logic fin);
        cbf_pkg::t_out_word v;
        v.vertex_x = x[31:0];
        v.vertex_y = y[31:0];
        v.path_length = l;
        v.last = fin;
        return v;
    endfunction

    // work out the vertices of one accepted command word
    task automatic predict_vertices(cbf_pkg::t_in_word w, bit push);
        longint px, py, qx, qy, n;
        px = pr_cur_x;
        py = pr_cur_y;
        case (cbf_pkg::t_cmd'(w.cmd))
            cbf_pkg::CMD_START: begin
                pr_len = 0;
                pr_cur_x = w.end_x;
                pr_cur_y = w.end_y;
                if (push) queue_vertex(mk_vertex(w.end_x, w.end_y, pr_len, 1'b1));
            end
            cbf_pkg::CMD_LINE: begin
                add_segment(px, py, w.end_x, w.end_y);
                pr_cur_x = w.end_x;
                pr_cur_y = w.end_y;
                if (push) queue_vertex(mk_vertex(w.end_x, w.end_y, pr_len, 1'b1));
            end
            cbf_pkg::CMD_CUBIC: begin
                n = pr_steps;
                if (n < 1) n = 1;
                if (n > 64) n = 64;
                for (longint j = 1; j <= n; j++) begin
                    qx = curve_coord(pr_cur_x, w.ctrl1_x, w.ctrl2_x, w.end_x, n, j);
                    qy = curve_coord(pr_cur_y, w.ctrl1_y, w.ctrl2_y, w.end_y, n, j);
                    add_segment(px, py, qx, qy);
                    if (push) queue_vertex(mk_vertex(qx, qy, pr_len, j == n));
                    px = qx;
                    py = qy;
                end
                pr_cur_x = w.end_x;
                pr_cur_y = w.end_y;
            end
            default: ;
        endcase
    endtask

    function automatic cbf_pkg::t_in_word mk_word(cbf_pkg::t_cmd c,
                                                  logic [31:0] c1x, logic [31:0] c1y,
                                                  logic [31:0] c2x, logic [31:0] c2y,
                                                  logic [31:0] ex, logic [31:0] ey);
        cbf_pkg::t_in_word w;
        w.cmd = c;
        w.ctrl1_x = c1x; w.ctrl1_y = c1y;
        w.ctrl2_x = c2x; w.ctrl2_y = c2y;
        w.end_x = ex; w.end_y = ey;
        return w;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    function automatic cbf_pkg::t_in_word rand_word();
        int  r;
        cbf_pkg::t_cmd c;
        r = $urandom_range(0, 99);
        c = r < 12 ? cbf_pkg::CMD_START : r < 45 ? cbf_pkg::CMD_LINE :
            r < 92 ? cbf_pkg::CMD_CUBIC : cbf_pkg::CMD_NONE;
        return mk_word(c, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
    endfunction

    // send one command word, with random gaps ahead of it
    task automatic send_word(cbf_pkg::t_in_word w, bit push);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
        predict_vertices(w, push);
    endtask

    // write the step count once the block has drained
    task automatic write_steps(logic [6:0] s);
        i_in_valid <= 1'b0;
        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pr_steps = s;
    endtask

    // receiver with random stalls and one long hold-off
    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold == 0) begin
                hold = 3000;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // compare each accepted vertex word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (vertex_q.size() == 0) begin
                $error("unexpected vertex word x=%h y=%h", o_out_data.vertex_x,
                       o_out_data.vertex_y);
                fails++;
            end else begin
                cbf_pkg::t_out_word e;
                e = vertex_q.pop_front();
                if (o_out_data.vertex_x !== e.vertex_x) begin
                    $error("vertex_x exp %h got %h", e.vertex_x, o_out_data.vertex_x);
                    fails++;
                end
                if (o_out_data.vertex_y !== e.vertex_y) begin
                    $error("vertex_y exp %h got %h", e.vertex_y, o_out_data.vertex_y);
                    fails++;
                end
                if (o_out_data.path_length !== e.path_length) begin
                    $error("path_length exp %h got %h", e.path_length,
                           o_out_data.path_length);
                    fails++;
                end
                if (o_out_data.last !== e.last) begin
                    $error("last exp %b got %b", e.last, o_out_data.last);
                    fails++;
                end
            end
        end
    end

    // main sequence
    initial begin : stimulus
        int          ph_steps[8] = '{1, 64, 0, 127, 2, 3, 7, 1};
        int          ph_mode[8]  = '{0, 0, 1, 2, 2, 3, 0, 3};
        int          ph_count[8] = '{80, 10, 80, 10, 80, 80, 60, 70};
        logic [31:0] ctl;
        pr_steps = cbf_pkg::STEPS_RESET;
        pr_cur_x = 0;
        pr_cur_y = 0;
        pr_len = 0;

        // directed rows; typed expectations only where obvious
        ctl = 32'h1234_5678;
        dir_tbl[0]  = '{mk_word(cbf_pkg::CMD_LINE, ctl, ~ctl, ctl, ~ctl, 0, 0), 1,
                        mk_vertex(0, 0, 0, 1)};
        dir_tbl[1]  = '{mk_word(cbf_pkg::CMD_START, ctl, ctl, ctl, ctl, C_MIN, C_MIN), 1,
                        mk_vertex(C_MIN, C_MIN, 0, 1)};
        dir_tbl[2]  = '{mk_word(cbf_pkg::CMD_LINE, 0, 0, 0, 0, C_MAX, C_MAX), 1,
                        mk_vertex(C_MAX, C_MAX, LEN_SAT, 1)};
        dir_tbl[3]  = '{mk_word(cbf_pkg::CMD_LINE, 0, 0, 0, 0, 0, 0), 1,
                        mk_vertex(0, 0, LEN_SAT, 1)};
        dir_tbl[4]  = '{mk_word(cbf_pkg::CMD_NONE, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN),
                        0, '0};
        dir_tbl[5]  = '{mk_word(cbf_pkg::CMD_START, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0), 1,
                        mk_vertex(0, 0, 0, 1)};
        dir_tbl[6]  = '{mk_word(cbf_pkg::CMD_LINE, C_MIN, C_MAX, C_MIN, C_MAX,
                                3 << 16, 4 << 16), 1,
                        mk_vertex(3 << 16, 4 << 16, 5 << 16, 1)};
        dir_tbl[7]  = '{mk_word(cbf_pkg::CMD_CUBIC, 1 << 20, 0, 0, 1 << 20, 1 << 20, 1 << 20),
                        0, '0};
        dir_tbl[8]  = '{mk_word(cbf_pkg::CMD_CUBIC, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX),
                        0, '0};
        dir_tbl[9]  = '{mk_word(cbf_pkg::CMD_CUBIC, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN),
                        0, '0};
        dir_tbl[10] = '{mk_word(cbf_pkg::CMD_START, 0, 0, 0, 0, C_MAX, C_MIN), 1,
                        mk_vertex(C_MAX, C_MIN, 0, 1)};
        dir_tbl[11] = '{mk_word(cbf_pkg::CMD_CUBIC, -1, 1, -1, 1, C_MAX, C_MIN), 0, '0};
        dir_tbl[12] = '{mk_word(cbf_pkg::CMD_CUBIC, 5, -7, 9, -3, -1, 1), 0, '0};
        dir_tbl[13] = '{mk_word(cbf_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0), 0, '0};
        dir_tbl[14] = '{mk_word(cbf_pkg::CMD_LINE, ~ctl, ctl, ~ctl, ctl, -1, -1), 0, '0};
        dir_tbl[15] = '{mk_word(cbf_pkg::CMD_CUBIC, 1, 1, 1, 1, 1, 1), 0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++) begin
            if (dir_tbl[k].chk) queue_vertex(dir_tbl[k].e);
            send_word(dir_tbl[k].w, !dir_tbl[k].chk);
        end

        // random phases over several step settings and idle patterns
        for (int p = 0; p < 8; p++) begin
            write_steps(7'(ph_steps[p]));
            send_idle_pct = (ph_mode[p] == 1) ? 83 : (ph_mode[p] == 3) ? 15 : 0;
            stall_pct     = (ph_mode[p] == 2) ? 83 : (ph_mode[p] == 3) ? 15 : 0;
            if (p == 0) hold_req = 1;
            for (int k = 0; k < ph_count[p]; k++) send_word(rand_word(), 1);
        end
        i_in_valid <= 1'b0;

        while (vertex_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fails == 0 && vertex_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
sv/cbf_pkg.sv
sv/cbf_ctrl.sv
sv/cbf_dp.sv
sv/cubic_bezier_flattener_arclen.sv
sv/cbf_checker.sv
verif/tb_cubic_bezier_flattener_arclen.sv
